### hdl/tdsm_pkg.sv
// table driven state machine: shared field widths, command and status codes
// no dependencies
`default_nettype none

package tdsm_pkg;

  localparam int CMD_W    = 3;
  localparam int FIELD_W  = 4;
  localparam int IDX_W    = 7;
  localparam int RANK_W   = 6;
  localparam int STATUS_W = 3;
  localparam int STATE_W  = 5;
  localparam int VALUE_W  = 6;
  localparam int CFG_W    = 5;
  localparam int ENTRY_W  = FIELD_W + 1;

  localparam logic [STATE_W-1:0] NOT_STARTED = 5'd16;
  localparam logic [CFG_W-1:0]   FINAL_NONE  = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 3'd0,
    CMD_APPEND  = 3'd1,
    CMD_WRITE   = 3'd2,
    CMD_EXECUTE = 3'd3,
    CMD_COUNT   = 3'd4,
    CMD_FIND    = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_WRONG_RUN = 3'd1,
    ST_RANGE     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NO_EFFECT = 3'd4
  } status_t;

endpackage

`default_nettype wire

### hdl/table_driven_state_machine_top.sv
// programmable table driven state machine: command sequencer, next-state table in ram
// depends on tdsm_pkg and tdsm_ram
//
// usage
//   input words carry one command each (start, append, write at index, execute,
//   count, find nth) and are taken when in_valid is high and in_stall low.
//   every word gives exactly one result word on the out_ channel, taken when
//   out_valid is high and out_stall low. final_state is written through
//   cfg_wr_en / cfg_wr_data; the user must do so only while the block is idle,
//   which the block itself does not enforce. the block handles one word at a
//   time: in_stall is low only in the idle state. start, append, write and
//   rejected commands pass from idle to the finish state, then to the output
//   register; execute first visits the exec state for one registered read of the
//   next-state table. count and find nth read one table column per cycle through
//   the single ram read port, a shared counter and one compare. a finished result
//   waits in the output register while the next word is taken; if the receiver
//   stalls, the sequencer holds the next result until the output register is free.
//   after reset a clearing pass writes every table entry as undefined, one per
//   cycle (NUM_STATES * 2^ceil(log2(NUM_TRANSITIONS)) entries, 512 by default),
//   with in_stall high. the machine starts in the not started state.
`default_nettype none

module table_driven_state_machine_top import tdsm_pkg::*; #(
  parameter int NUM_STATES      = 16,
  parameter int NUM_TRANSITIONS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_W-1:0]     cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [CMD_W-1:0]     in_command,
  input  wire logic [FIELD_W-1:0]   in_from_state,
  input  wire logic [FIELD_W-1:0]   in_to_state,
  input  wire logic signed [IDX_W-1:0] in_transition_index,
  input  wire logic [RANK_W-1:0]    in_rank,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [STATUS_W-1:0]       out_status,
  output logic [STATE_W-1:0]        out_current_state,
  output logic                      out_finished,
  output logic                      out_state_entered,
  output logic [VALUE_W-1:0]        out_value
);

  localparam int ROW_W = $clog2(NUM_STATES);
  localparam int COL_W = $clog2(NUM_TRANSITIONS);
  localparam int AW    = ROW_W + COL_W;
  localparam int DEPTH = NUM_STATES * (1 << COL_W);
  localparam int CW    = COL_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FINISH
  } seq_state_t;

  seq_state_t              state_r, state_nxt;
  logic [AW-1:0]           clr_r, clr_nxt;
  logic [CW-1:0]           col_r, col_nxt;
  logic [STATE_W-1:0]      present_r, present_nxt;
  logic [VALUE_W-1:0]      used_r, used_nxt;
  logic [CFG_W-1:0]        final_r, final_nxt;
  logic                    is_find_r, is_find_nxt;
  logic [RANK_W-1:0]       rank_r, rank_nxt;
  status_t                 res_status_r, res_status_nxt;
  logic                    res_entered_r, res_entered_nxt;
  logic [VALUE_W-1:0]      res_value_r, res_value_nxt;
  logic [VALUE_W-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_W-1:0]      found_r, found_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [STATE_W-1:0]      out_state_r, out_state_nxt;
  logic                    out_finished_r, out_finished_nxt;
  logic                    out_entered_r, out_entered_nxt;
  logic [VALUE_W-1:0]      out_value_r, out_value_nxt;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [ENTRY_W-1:0]      ram_rdata;

  logic                    started;
  logic                    from_ok;
  logic                    to_ok;
  logic                    idx_none;
  logic                    idx_col_ok;
  logic                    idx_le_used;
  logic                    can_load;
  logic [VALUE_W-1:0]      scan_col;
  logic [VALUE_W-1:0]      cnt_inc;

  tdsm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign started     = present_r < STATE_W'(NUM_STATES);
  assign from_ok     = STATE_W'(in_from_state) < STATE_W'(NUM_STATES);
  assign to_ok       = STATE_W'(in_to_state) < STATE_W'(NUM_STATES);
  assign idx_none    = &in_transition_index;
  assign idx_col_ok  = !in_transition_index[IDX_W-1] &&
                       (VALUE_W'(in_transition_index[VALUE_W-1:0]) <
                        VALUE_W'(NUM_TRANSITIONS));
  assign idx_le_used = in_transition_index[VALUE_W-1:0] <= used_r;
  assign can_load    = !out_valid_r || !out_stall;
  assign scan_col    = VALUE_W'(col_r) - VALUE_W'(1);
  assign cnt_inc     = cnt_r + VALUE_W'(1);

  // read address: execute column at accept, scan column otherwise
  always_comb begin
    if (state_r == S_IDLE) begin
      ram_raddr = {present_r[ROW_W-1:0], in_transition_index[COL_W-1:0]};
    end else begin
      ram_raddr = {present_r[ROW_W-1:0], col_r[COL_W-1:0]};
    end
  end

  always_comb begin
    state_nxt        = state_r;
    clr_nxt          = clr_r;
    col_nxt          = col_r;
    present_nxt      = present_r;
    used_nxt         = used_r;
    final_nxt        = cfg_wr_en ? cfg_wr_data : final_r;
    is_find_nxt      = is_find_r;
    rank_nxt         = rank_r;
    res_status_nxt   = res_status_r;
    res_entered_nxt  = res_entered_r;
    res_value_nxt    = res_value_r;
    cnt_nxt          = cnt_r;
    found_nxt        = found_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_status_nxt   = out_status_r;
    out_state_nxt    = out_state_r;
    out_finished_nxt = out_finished_r;
    out_entered_nxt  = out_entered_r;
    out_value_nxt    = out_value_r;
    ram_we           = 1'b0;
    ram_waddr        = {in_from_state[ROW_W-1:0], used_r[COL_W-1:0]};
    ram_wdata        = {1'b1, in_to_state};

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_status_nxt  = ST_OK;
          res_entered_nxt = 1'b0;
          res_value_nxt   = '0;
          rank_nxt        = in_rank;
          is_find_nxt     = (cmd_t'(in_command) == CMD_FIND);
          state_nxt       = S_FINISH;
          case (cmd_t'(in_command))
            CMD_START: begin
              if (started) begin
                res_status_nxt = ST_WRONG_RUN;
              end else begin
                present_nxt     = '0;
                res_entered_nxt = 1'b1;
              end
            end
            CMD_APPEND: begin
              if (used_r >= VALUE_W'(NUM_TRANSITIONS)) begin
                res_status_nxt = ST_FULL;
              end else if (!from_ok || !to_ok) begin
                res_status_nxt = ST_RANGE;
              end else begin
                ram_we        = 1'b1;
                res_value_nxt = used_r;
                used_nxt      = used_r + VALUE_W'(1);
              end
            end
            CMD_WRITE: begin
              ram_waddr = {in_from_state[ROW_W-1:0], in_transition_index[COL_W-1:0]};
              if (!idx_col_ok || !from_ok || !to_ok) begin
                res_status_nxt = ST_RANGE;
              end else begin
                ram_we = 1'b1;
              end
            end
            CMD_EXECUTE: begin
              if (!started) begin
                res_status_nxt = ST_WRONG_RUN;
              end else if (idx_none) begin
                res_status_nxt = ST_OK;
              end else if (!idx_col_ok || !idx_le_used) begin
                res_status_nxt = ST_RANGE;
              end else begin
                state_nxt = S_EXEC;
              end
            end
            CMD_COUNT, CMD_FIND: begin
              if (!started) begin
                res_status_nxt = ST_WRONG_RUN;
              end else begin
                cnt_nxt   = '0;
                found_nxt = '0;
                col_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              res_status_nxt = ST_NO_EFFECT;
            end
          endcase
        end
      end
      S_EXEC: begin
        if (!ram_rdata[ENTRY_W-1]) begin
          res_status_nxt = ST_NO_EFFECT;
        end else begin
          present_nxt     = STATE_W'(ram_rdata[FIELD_W-1:0]);
          res_entered_nxt = 1'b1;
        end
        state_nxt = S_FINISH;
      end
      S_SCAN: begin
        // data of column col_r - 1 arrives while col_r is addressed
        col_nxt = col_r + CW'(1);
        if (col_r != '0) begin
          if (ram_rdata[ENTRY_W-1] && (scan_col < used_r)) begin
            cnt_nxt = cnt_inc;
            if (cnt_inc == rank_r) begin
              found_nxt = scan_col;
            end
          end
        end
        if (col_r == CW'(NUM_TRANSITIONS)) begin
          state_nxt = S_FINISH;
          if (!is_find_r) begin
            res_value_nxt = cnt_nxt;
          end else if ((rank_r == '0) || (rank_r > cnt_nxt)) begin
            res_status_nxt = ST_RANGE;
          end else begin
            res_value_nxt = found_nxt;
          end
        end
      end
      S_FINISH: begin
        if (can_load) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = res_status_r;
          out_state_nxt    = present_r;
          out_finished_nxt = started && (present_r == final_r);
          out_entered_nxt  = res_entered_r;
          out_value_nxt    = res_value_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      present_r   <= NOT_STARTED;
      used_r      <= '0;
      final_r     <= FINAL_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      present_r   <= present_nxt;
      used_r      <= used_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
    col_r          <= col_nxt;
    is_find_r      <= is_find_nxt;
    rank_r         <= rank_nxt;
    res_status_r   <= res_status_nxt;
    res_entered_r  <= res_entered_nxt;
    res_value_r    <= res_value_nxt;
    cnt_r          <= cnt_nxt;
    found_r        <= found_nxt;
    out_status_r   <= out_status_nxt;
    out_state_r    <= out_state_nxt;
    out_finished_r <= out_finished_nxt;
    out_entered_r  <= out_entered_nxt;
    out_value_r    <= out_value_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_current_state = out_state_r;
  assign out_finished      = out_finished_r;
  assign out_state_entered = out_entered_r;
  assign out_value         = out_value_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= VALUE_W'(NUM_TRANSITIONS))
    else $error("transition count beyond table width");

  a_finished_started: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_finished_r |-> out_state_r < STATE_W'(NUM_STATES))
    else $error("finished flag while machine not started");

  a_entered_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_entered_r |-> out_status_r == ST_OK)
    else $error("state entered with error status");

  a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_value_r != '0) |-> out_status_r == ST_OK)
    else $error("nonzero value with error status");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) && out_valid_r && out_stall |=> state_r == S_FINISH)
    else $error("result overwrote a stalled word");

endmodule

`default_nettype wire

### hdl/tdsm_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module tdsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
